// ----- design/lfac_pkg.sv -----
// Shared constants, types and helper functions for the LRU cache trace simulator.
package lfac_pkg;

   // Store geometry
   localparam int ENTRIES = 64;
   localparam int KEY_W   = 48;
   localparam int OCC_W   = $clog2(ENTRIES + 1);

   // Field widths fixed by the request and response formats
   localparam int TS_W     = 63;
   localparam int EVK_W    = 48;
   localparam int CNT_W    = 32;
   localparam int NUM_CNT  = 8;
   localparam int CNT_IDX_W = 3;
   localparam int CAP_W    = 7;
   localparam int CMP_W    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 63;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIN_START = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIN_END   = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;
   localparam logic [TS_W-1:0]  WIN_END_RESET = {TS_W{1'b1}};

   // Statistic counter slots, in response order
   localparam logic [CNT_IDX_W-1:0] CNT_HIT   = 3'd0;
   localparam logic [CNT_IDX_W-1:0] CNT_MISS  = 3'd1;
   localparam logic [CNT_IDX_W-1:0] CNT_READ  = 3'd2;
   localparam logic [CNT_IDX_W-1:0] CNT_WRITE = 3'd3;
   localparam logic [CNT_IDX_W-1:0] CNT_RHIT  = 3'd4;
   localparam logic [CNT_IDX_W-1:0] CNT_RMISS = 3'd5;
   localparam logic [CNT_IDX_W-1:0] CNT_WHIT  = 3'd6;
   localparam logic [CNT_IDX_W-1:0] CNT_WMISS = 3'd7;

   // Stream payload layout
   localparam int REQ_FIELDS_W = TS_W + KEY_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 3 + EVK_W + NUM_CNT * CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_INWIN_BIT = 0;
   localparam int RSP_HIT_BIT   = 1;
   localparam int RSP_EVICT_BIT = 2;
   localparam int RSP_EVK_LSB   = 3;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic    look;
      logic    update;
      logic    hit;
      logic    evict;
      key_type key;
   } cell_ctrl_type;

   // Link from one cell to its next-older neighbor
   typedef struct packed {
      key_type key;
      logic    valid;
      logic    seen;
   } link_type;

   function automatic cnt_type sat_inc(cnt_type c, logic en);
      cnt_type r;
      r = c;
      if (en && (c != {CNT_W{1'b1}})) begin
         r = c + cnt_type'(1);
      end
      return r;
   endfunction

   function automatic logic [EVK_W-1:0] to_evk(key_type k);
      logic [63:0] w;
      w = 64'(k);
      return w[EVK_W-1:0];
   endfunction

endpackage

// ----- design/lfac_cell.sv -----
// One recency slot: stored key, valid bit, registered match and shift toward older slots.
module lfac_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lfac_pkg::cell_ctrl_type ctrl,
   input  lfac_pkg::link_type     prev,
   input  logic                   next_valid,
   output lfac_pkg::link_type     link,
   output logic                   match,
   output logic                   tail
);
   import lfac_pkg::*;

   key_type key_ff;
   logic    valid_ff;
   logic    match_ff;
   logic    shift;

   // Decide whether this slot takes the key of its younger neighbor
   always_comb begin
      if (ctrl.hit) begin
         shift = ctrl.update && !prev.seen;
      end else if (ctrl.evict) begin
         shift = ctrl.update && valid_ff;
      end else begin
         shift = ctrl.update && prev.valid;
      end
   end

   // Hold valid and match; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (shift) begin
            valid_ff <= prev.valid;
         end
         if (ctrl.look) begin
            match_ff <= valid_ff && (key_ff == ctrl.key);
         end
      end
   end

   // Advance the key down the chain
   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff <= prev.key;
      end
   end

   assign link.key   = key_ff;
   assign link.valid = valid_ff;
   assign link.seen  = prev.seen | match_ff;
   assign match      = match_ff;
   assign tail       = valid_ff & ~next_valid;

endmodule

// ----- design/lfac_chain.sv -----
// Row of recency cells, most recent first, with hit and tail-key collection.
module lfac_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  lfac_pkg::cell_ctrl_type ctrl,
   output logic                   hit_any,
   output lfac_pkg::key_type      tail_key
);
   import lfac_pkg::*;

   link_type prev_link [ENTRIES];
   link_type out_link  [ENTRIES];
   logic     next_valid [ENTRIES];
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] tail_vec;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         // The head cell is fed the request key as a valid entry
         if (g == 0) begin : g_head
            assign prev_link[g].key   = ctrl.key;
            assign prev_link[g].valid = 1'b1;
            assign prev_link[g].seen  = 1'b0;
         end else begin : g_body
            assign prev_link[g] = out_link[g-1];
         end
         if (g == ENTRIES - 1) begin : g_last
            assign next_valid[g] = 1'b0;
         end else begin : g_mid
            assign next_valid[g] = out_link[g+1].valid;
         end

         lfac_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev       (prev_link[g]),
            .next_valid (next_valid[g]),
            .link       (out_link[g]),
            .match      (match_vec[g]),
            .tail       (tail_vec[g])
         );
      end
   endgenerate

   assign hit_any = |match_vec;

   // Select the key of the least recent valid cell
   always_comb begin
      tail_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         tail_key = tail_key | (out_link[i].key & {KEY_W{tail_vec[i]}});
      end
   end

endmodule

// ----- design/lru_fully_assoc_cache_sim.sv -----
// A request accepted in S_IDLE or at the update is compared by the cell row in S_LOOK; the row
// shifts and the response is registered in S_UPD, and no new request is taken before that update.
// A stalled response holds the update cycle, so the next request waits while rsp_tvalid stays.
// Reset clears all valid bits, occupancy, statistic counters and the response valid flag,
// and returns capacity to 64 and the window to the full timestamp range.
module lru_fully_assoc_cache_sim (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: timestamp, block_key
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lfac_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: is_read
   input  logic                               req_tuser,
   // rsp_tdata: in_window, hit, evicted, evicted_key, hit_count, miss_count, read_count,
   //   write_count, read_hit_count, read_miss_count, write_hit_count, write_miss_count
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lfac_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [lfac_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [lfac_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lfac_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD} state_type;

   state_type               state_ff, state_in;
   logic [CAP_W-1:0]        cap_ff;
   logic [TS_W-1:0]         wstart_ff;
   logic [TS_W-1:0]         wend_ff;
   logic [TS_W-1:0]         ts_ff;
   key_type                 key_ff;
   logic                    rd_ff;
   logic                    inwin_ff;
   key_type                 tail_ff;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   cnt_type                 cnt_ff [NUM_CNT];
   cnt_type                 cnt_in [NUM_CNT];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   cell_ctrl_type           ctrl;
   logic                    hit_any;
   key_type                 tail_key;
   logic                    upd_go;
   logic                    req_go;
   logic                    hit;
   logic                    evict;
   logic                    full;
   logic [CMP_W-1:0]        cap_ext;
   logic [CMP_W-1:0]        cap_eff;
   logic [EVK_W-1:0]        evk;

   lfac_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .hit_any  (hit_any),
      .tail_key (tail_key)
   );

   // Handshake control
   assign upd_go     = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE) || upd_go;
   assign req_go     = req_tvalid && req_tready;

   // Effective capacity: zero counts as one, above the row size clamps to it
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign full  = CMP_W'(occ_ff) >= cap_eff;
   assign hit   = inwin_ff && hit_any;
   assign evict = inwin_ff && !hit_any && full;
   assign evk   = evict ? to_evk(tail_ff) : '0;

   // Broadcast to the cell row
   always_comb begin
      ctrl.look   = (state_ff == S_LOOK);
      ctrl.update = upd_go && inwin_ff;
      ctrl.hit    = hit_any;
      ctrl.evict  = !hit_any && full;
      ctrl.key    = key_ff;
   end

   // Next state, occupancy, counters and response
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_go) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (req_go) begin
               state_in = S_LOOK;
            end else if (upd_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      occ_in = occ_ff;
      if (upd_go && inwin_ff && !hit_any && !full) begin
         occ_in = occ_ff + OCC_W'(1);
      end

      cnt_in[CNT_HIT]   = sat_inc(cnt_ff[CNT_HIT],   hit);
      cnt_in[CNT_MISS]  = sat_inc(cnt_ff[CNT_MISS],  inwin_ff && !hit_any);
      cnt_in[CNT_READ]  = sat_inc(cnt_ff[CNT_READ],  inwin_ff && rd_ff);
      cnt_in[CNT_WRITE] = sat_inc(cnt_ff[CNT_WRITE], inwin_ff && !rd_ff);
      cnt_in[CNT_RHIT]  = sat_inc(cnt_ff[CNT_RHIT],  hit && rd_ff);
      cnt_in[CNT_RMISS] = sat_inc(cnt_ff[CNT_RMISS], inwin_ff && !hit_any && rd_ff);
      cnt_in[CNT_WHIT]  = sat_inc(cnt_ff[CNT_WHIT],  hit && !rd_ff);
      cnt_in[CNT_WMISS] = sat_inc(cnt_ff[CNT_WMISS], inwin_ff && !hit_any && !rd_ff);

      rsp_data_in = RSP_DATA_W'({cnt_in[CNT_WMISS], cnt_in[CNT_WHIT], cnt_in[CNT_RMISS],
                                 cnt_in[CNT_RHIT], cnt_in[CNT_WRITE], cnt_in[CNT_READ],
                                 cnt_in[CNT_MISS], cnt_in[CNT_HIT], evk, evict, hit,
                                 inwin_ff});

      rsp_valid_in = rsp_valid_ff;
      if (upd_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State, configuration, request, statistics and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         wstart_ff    <= '0;
         wend_ff      <= WIN_END_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_CAPACITY:  cap_ff    <= csr_wdata[CAP_W-1:0];
               CSR_WIN_START: wstart_ff <= csr_wdata[TS_W-1:0];
               CSR_WIN_END:   wend_ff   <= csr_wdata[TS_W-1:0];
               default: begin
               end
            endcase
         end
         if (upd_go) begin
            occ_ff      <= occ_in;
            rsp_data_ff <= rsp_data_in;
            for (int i = 0; i < NUM_CNT; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
         end
         if (req_go) begin
            ts_ff  <= req_tdata[TS_W-1:0];
            key_ff <= req_tdata[TS_W +: KEY_W];
            rd_ff  <= req_tuser;
         end
         if (state_ff == S_LOOK) begin
            inwin_ff <= (ts_ff >= wstart_ff) && (ts_ff <= wend_ff);
            tail_ff  <= tail_key;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- design/lfac_check.sv -----
// Port-level checks for the LRU cache trace simulator, bound to the top level.
module lfac_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lfac_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import lfac_pkg::*;

   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // An accepted request blocks the next one for the compare cycle
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during lookup");

   // Out-of-window accesses report no hit and no eviction
   a_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_INWIN_BIT] |->
         !rsp_tdata[RSP_HIT_BIT] && !rsp_tdata[RSP_EVICT_BIT])
      else $error("flags set on an out-of-window access");

   // A hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_HIT_BIT] && rsp_tdata[RSP_EVICT_BIT]))
      else $error("hit and eviction together");

   // Evicted key is zero unless an eviction happened
   a_evk_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_EVICT_BIT] |-> rsp_tdata[RSP_EVK_LSB +: EVK_W] == '0)
      else $error("evicted key without eviction");

endmodule

bind lru_fully_assoc_cache_sim lfac_check u_lfac_check (.*);

// ----- verif/lru_fully_assoc_cache_sim_tb.sv -----
// Self-checking testbench for the fully associative LRU cache trace simulator.
module lru_fully_assoc_cache_sim_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfac_pkg::*;

   localparam logic [TS_W-1:0]  TS_MAX  = {TS_W{1'b1}};
   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 4;

   // One response, field by field
   typedef struct packed {
      logic                          in_window;
      logic                          hit;
      logic                          evicted;
      logic [EVK_W-1:0]              evk;
      logic [NUM_CNT-1:0][CNT_W-1:0] tally;
   } cache_result_type;

   // Tracks recency order and running totals, holds the responses still owed
   class cache_scoreboard;
      key_type                       lru_keys[$];
      logic [NUM_CNT-1:0][CNT_W-1:0] tally;
      logic [CAP_W-1:0]              cap_reg;
      logic [TS_W-1:0]               win_lo;
      logic [TS_W-1:0]               win_hi;
      cache_result_type              expected_results[$];
      string tally_name[NUM_CNT] = '{"hit_count", "miss_count", "read_count", "write_count",
                                     "read_hit_count", "read_miss_count", "write_hit_count",
                                     "write_miss_count"};
      int errors, checked, accepted, hits_seen, evicts_seen, outside_seen;

      function new();
         tally   = '0;
         cap_reg = CAP_RESET;
         win_lo  = '0;
         win_hi  = WIN_END_RESET;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void set_config(logic [CAP_W-1:0] cap, logic [TS_W-1:0] lo,
                               logic [TS_W-1:0] hi);
         cap_reg = cap;
         win_lo  = lo;
         win_hi  = hi;
      endfunction

      // Zero means one entry; anything past the built size clamps to it
      function int usable_entries();
         int c;
         c = int'(cap_reg);
         if (c == 0) c = 1;
         if (c > ENTRIES) c = ENTRIES;
         return c;
      endfunction

      function void bump(logic [CNT_IDX_W-1:0] idx);
         if (tally[idx] != {CNT_W{1'b1}}) tally[idx] = tally[idx] + 1'b1;
      endfunction

      // Apply one accepted request to the shadow store and queue its response
      function void predict_access(logic [TS_W-1:0] ts, key_type key, logic rd);
         cache_result_type r;
         int pos;
         int last;
         r = '0;
         pos = -1;
         accepted++;
         r.in_window = (ts >= win_lo) && (ts <= win_hi);
         if (r.in_window) begin
            bump(rd ? CNT_READ : CNT_WRITE);
            foreach (lru_keys[i]) begin
               if (pos < 0 && lru_keys[i] == key) pos = i;
            end
            if (pos >= 0) begin
               r.hit = 1'b1;
               hits_seen++;
               lru_keys.delete(pos);
               bump(CNT_HIT);
               bump(rd ? CNT_RHIT : CNT_WHIT);
            end else begin
               bump(CNT_MISS);
               bump(rd ? CNT_RMISS : CNT_WMISS);
               if (lru_keys.size() >= usable_entries()) begin
                  // drop the least recent key from the tail
                  last = lru_keys.size() - 1;
                  r.evicted = 1'b1;
                  r.evk = lru_keys[last];
                  lru_keys.delete(last);
                  evicts_seen++;
               end
            end
            lru_keys.insert(0, key);
         end else begin
            outside_seen++;
         end
         r.tally = tally;
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
         end
      endfunction

      // Compare one accepted response against the oldest expectation
      function void check_result(logic [RSP_DATA_W-1:0] d);
         cache_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("[%0t] unexpected response: expected none, actual 0x%0h", $time, d);
            return;
         end
         want = expected_results.pop_front();
         checked++;
         compare_field("in_window", 64'(want.in_window), 64'(d[RSP_INWIN_BIT]));
         compare_field("hit", 64'(want.hit), 64'(d[RSP_HIT_BIT]));
         compare_field("evicted", 64'(want.evicted), 64'(d[RSP_EVICT_BIT]));
         compare_field("evicted_key", 64'(want.evk), 64'(d[RSP_EVK_LSB +: EVK_W]));
         for (int i = 0; i < NUM_CNT; i++) begin
            compare_field(tally_name[i], 64'(want.tally[i]),
                          64'(d[RSP_EVK_LSB + EVK_W + i*CNT_W +: CNT_W]));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // req_tdata: timestamp, block_key
   logic [REQ_DATA_W-1:0] req_tdata;
   // req_tuser: is_read
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // rsp_tdata: in_window, hit, evicted, evicted_key, hit_count, miss_count, read_count,
   //   write_count, read_hit_count, read_miss_count, write_hit_count, write_miss_count
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cache_scoreboard board;
   key_type         key_pool[96];
   int              cycles;
   int              settings_used;
   int              left_in_burst;
   int              hold_left;
   int              stretch_left;
   int              stall_mode;
   int              stall_phase;
   bit              long_hold_done;

   lru_fully_assoc_cache_sim dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Receiver: check each response, then pick the ready level for the next cycle
   initial begin
      rsp_tready <= 1'b0;
      hold_left = 0;
      stretch_left = 0;
      stall_mode = 0;
      stall_phase = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && board.checked >= 150) begin
            // hold off long enough for the request side to back up
            long_hold_done = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               stretch_left = $urandom_range(8, 60);
            end
            stretch_left--;
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= (stall_phase % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offer one request and hold it until the block takes it
   task automatic send_access(logic [TS_W-1:0] ts, key_type key, logic rd);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({key, ts});
      req_tuser  <= rd;
      do @(posedge clock); while (!req_tready);
      board.predict_access(ts, key, rd);
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      left_in_burst = 0;
   endtask

   // Write all three registers; only called while the block is idle
   task automatic apply_setting(logic [CAP_W-1:0] cap, logic [TS_W-1:0] lo,
                                logic [TS_W-1:0] hi);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_CAPACITY;
      csr_wdata <= CSR_DATA_W'(cap);
      @(posedge clock);
      csr_addr  <= CSR_WIN_START;
      csr_wdata <= CSR_DATA_W'(lo);
      @(posedge clock);
      csr_addr  <= CSR_WIN_END;
      csr_wdata <= CSR_DATA_W'(hi);
      @(posedge clock);
      csr_we    <= 1'b0;
      board.set_config(cap, lo, hi);
      settings_used++;
   endtask

   // Favor the window edges and their neighbors, with some fully random stamps
   function automatic logic [TS_W-1:0] pick_stamp(logic [TS_W-1:0] lo, logic [TS_W-1:0] hi);
      logic [63:0] r;
      logic [63:0] span;
      int sel;
      r = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (sel == 0) return lo;
      if (sel == 1) return hi;
      if (sel == 2 && lo != '0) return lo - 1'b1;
      if (sel == 3 && hi != TS_MAX) return hi + 1'b1;
      if (sel == 4 || hi < lo) return r[TS_W-1:0];
      span = 64'(hi - lo);
      if (span == 64'(TS_MAX)) return r[TS_W-1:0];
      return lo + TS_W'(r % (span + 1));
   endfunction

   // One random phase: new setting, then bursts of accesses over part of the key pool
   task automatic run_phase(int count, int pool_n, logic [CAP_W-1:0] cap,
                            logic [TS_W-1:0] lo, logic [TS_W-1:0] hi, bit pause_mid);
      key_type key;
      int gap;
      apply_setting(cap, lo, hi);
      for (int n = 0; n < count; n++) begin
         if (pause_mid && n == count / 2) begin
            drain();
         end
         if (left_in_burst == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            left_in_burst = $urandom_range(1, 24);
         end
         if ($urandom_range(0, 9) == 0) key = key_type'({$urandom, $urandom});
         else key = key_pool[$urandom_range(0, pool_n - 1)];
         send_access(pick_stamp(lo, hi), key, 1'($urandom_range(0, 1)));
         left_in_burst--;
      end
      drain();
   endtask

   initial begin
      board = new();
      settings_used = 0;
      left_in_burst = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_CAPACITY;
      csr_wdata  <= '0;
      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      for (int i = 2; i < 96; i++) key_pool[i] = key_type'({$urandom, $urandom});
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme keys and stamps at the reset setting
      send_access('0, '0, 1'b1);
      send_access(TS_MAX, KEY_MAX, 1'b0);
      send_access(TS_MAX, '0, 1'b0);
      send_access(63'h2AAA_AAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b1);
      send_access(63'h5555_5555_5555_5555, 48'h5555_5555_5555, 1'b0);
      send_access(63'd1, KEY_MAX, 1'b1);
      send_access(63'd2, 48'h5555_5555_5555, 1'b1);
      drain();

      // Directed: narrow window edges, capacity below the current fill
      apply_setting(7'd2, 63'd100, 63'd200);
      send_access(63'd99, 48'h10, 1'b1);
      send_access(63'd100, 48'h10, 1'b1);
      send_access(63'd200, 48'h20, 1'b0);
      send_access(63'd201, 48'h30, 1'b0);
      send_access(63'd150, 48'h10, 1'b0);
      send_access(63'd150, 48'h40, 1'b1);
      drain();

      // Directed: window start above end, then capacity zero
      apply_setting(7'd0, 63'd300, 63'd299);
      send_access(63'd299, 48'h10, 1'b1);
      send_access(63'd300, 48'h10, 1'b0);
      drain();
      apply_setting(7'd0, '0, TS_MAX);
      send_access(63'd5, 48'hA1, 1'b1);
      send_access(63'd6, 48'hB2, 1'b0);
      send_access(63'd7, 48'hB2, 1'b1);
      drain();

      // Directed: capacity beyond the built size
      apply_setting(7'd127, '0, TS_MAX);
      send_access(63'd8, 48'hC3, 1'b0);
      send_access(63'd9, 48'hA1, 1'b1);
      drain();

      // Random phases across capacities and windows
      run_phase(250, 90, 7'd64, '0, TS_MAX, 1'b1);
      run_phase(100, 90, 7'd3, '0, TS_MAX, 1'b0);
      run_phase(150, 20, 7'd8, 63'd1000, 63'd5000, 1'b0);
      run_phase(80, 4, 7'd1, '0, TS_MAX, 1'b0);
      run_phase(80, 4, 7'd0, '0, TS_MAX, 1'b0);
      run_phase(150, 90, 7'd127, '0, TS_MAX, 1'b0);
      run_phase(60, 30, 7'd16, 63'h4000_0000_0000_0000, 63'h3FFF_FFFF_FFFF_FFF0, 1'b0);
      run_phase(150, 40, 7'd33, TS_MAX - 63'd1000, TS_MAX, 1'b0);
      run_phase(100, 10, 7'd5, '0, 63'd500, 1'b0);
      run_phase(150, 70, 7'd64, '0, TS_MAX, 1'b0);

      // Let any stray response surface before the verdict
      repeat (20) @(posedge clock);
      if (board.pending() > 0) begin
         board.errors += board.pending();
         $display("[%0t] %0d responses never arrived", $time, board.pending());
      end
      $display("Ran %0d requests over %0d register settings; %0d responses checked.",
               board.accepted, settings_used, board.checked);
      $display("Saw %0d hits, %0d evictions and %0d out-of-window requests; %0d errors.",
               board.hits_seen, board.evicts_seen, board.outside_seen, board.errors);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
